@@ rtl/mcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared widths, codes and types of the midpoint circle point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpg_pkg;

  localparam int RADIUS_BITS = 12;
  localparam int COORD_BITS  = RADIUS_BITS + 1;
  localparam int DEC_BITS    = RADIUS_BITS + 6;
  localparam int SI_BITS     = RADIUS_BITS + 3;
  localparam int QUAD_BITS   = 4;
  localparam int NUM_POINTS  = 2 * QUAD_BITS;
  localparam int SEL_BITS    = $clog2(NUM_POINTS);

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = Q_PTR_BITS + 1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef struct packed {
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic [QUAD_BITS-1:0]   mask;
    logic                   done;
  } mcpg_job_t;

endpackage

`default_nettype wire

@@ rtl/mcpg_front.sv @@
// ----------------------------------------------------------------------------
// mcpg_front
// Accepts start and step transactions, advances the octant walk and queues
// one job per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_front
  import mcpg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   func,
  input  wire logic [RADIUS_BITS-1:0] radius,
  input  wire logic [QUAD_BITS-1:0]   quadrants,
  input  wire logic                   q_full,
  output logic                        q_push,
  output mcpg_job_t                   q_job
);

  logic [RADIUS_BITS-1:0] walk_x, walk_x_next;
  logic [RADIUS_BITS-1:0] walk_y, walk_y_next;
  logic [DEC_BITS-1:0]    decision, decision_next;
  logic [DEC_BITS-1:0]    step_increment, step_increment_next;
  logic [SI_BITS-1:0]     straight_increment, straight_increment_next;
  logic [QUAD_BITS-1:0]   quadrant_mask;
  logic                   active;
  logic                   accept;
  logic                   done_next;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && (func == FUNC_STEP);

  always_comb begin
    walk_x_next             = walk_x + RADIUS_BITS'(1);
    walk_y_next             = walk_y;
    straight_increment_next = straight_increment + SI_BITS'(4);
    if (!decision[DEC_BITS-1]) begin
      decision_next       = decision + step_increment;
      step_increment_next = step_increment + DEC_BITS'(8);
      if (walk_y != '0) begin
        walk_y_next = walk_y - RADIUS_BITS'(1);
      end
    end else begin
      decision_next       = decision + DEC_BITS'(straight_increment);
      step_increment_next = step_increment + DEC_BITS'(4);
    end
    done_next = walk_x_next > walk_y_next;
  end

  always_comb begin
    if (active) begin
      q_job.x    = walk_x;
      q_job.y    = walk_y;
      q_job.mask = quadrant_mask;
      q_job.done = done_next;
    end else begin
      q_job.x    = '0;
      q_job.y    = '0;
      q_job.mask = '0;
      q_job.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x             <= '0;
      walk_y             <= '0;
      decision           <= '0;
      step_increment     <= '0;
      straight_increment <= SI_BITS'(6);
      quadrant_mask      <= '0;
      active             <= 1'b0;
    end else if (accept) begin
      if (func == FUNC_START) begin
        walk_x             <= '0;
        walk_y             <= radius;
        decision           <= DEC_BITS'(3) - DEC_BITS'({radius, 1'b0});
        step_increment     <= DEC_BITS'(10) - DEC_BITS'({radius, 2'b00});
        straight_increment <= SI_BITS'(6);
        quadrant_mask      <= quadrants;
        active             <= 1'b1;
      end else if (active) begin
        walk_x             <= walk_x_next;
        walk_y             <= walk_y_next;
        decision           <= decision_next;
        step_increment     <= step_increment_next;
        straight_increment <= straight_increment_next;
        active             <= !done_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mcpg_queue.sv @@
// ----------------------------------------------------------------------------
// mcpg_queue
// Short job queue between the walk front end and the point emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_queue
  import mcpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire mcpg_job_t push_job,
  input  wire logic      pop,
  output mcpg_job_t      head_job,
  output logic           full,
  output logic           empty
);

  mcpg_job_t               entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr;
  logic [Q_PTR_BITS-1:0]   rd_ptr;
  logic [Q_CNT_BITS-1:0]   count;

  assign full     = count == Q_CNT_BITS'(Q_DEPTH);
  assign empty    = count == '0;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mcpg_back.sv @@
// ----------------------------------------------------------------------------
// mcpg_back
// Takes queued jobs and emits the symmetric points through an output
// register, one result per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_back
  import mcpg_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  input  wire mcpg_job_t                    q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      point_x,
  output logic signed [COORD_BITS-1:0]      point_y,
  output logic                              point_valid,
  output logic                              last,
  output logic                              done_res
);

  logic                         jvalid;
  mcpg_job_t                    job;
  logic [NUM_POINTS-1:0]        pend;
  logic [NUM_POINTS-1:0]        pend_clear;
  logic [NUM_POINTS-1:0]        head_pend;
  logic [SEL_BITS-1:0]          sel;
  logic                         out_free;
  logic                         emit;
  logic                         emit_last;
  logic                         swap;
  logic                         neg_x;
  logic                         neg_y;
  logic [COORD_BITS-1:0]        mag_a;
  logic [COORD_BITS-1:0]        mag_b;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  always_comb begin
    sel = '0;
    for (int i = NUM_POINTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SEL_BITS'(i);
      end
    end
  end

  always_comb begin
    for (int q = 0; q < QUAD_BITS; q++) begin
      head_pend[2*q]   = q_head.mask[q];
      head_pend[2*q+1] = q_head.mask[q];
    end
  end

  assign pend_clear = pend & ~(NUM_POINTS'(1) << sel);
  assign out_free   = !out_valid || !out_stall;
  assign emit       = jvalid && out_free;
  assign emit_last  = (pend == '0) || (pend_clear == '0);
  assign q_pop      = !q_empty && (!jvalid || (emit && emit_last));

  assign swap  = sel[0];
  assign neg_x = (sel[SEL_BITS-1:1] == 2'd1) || (sel[SEL_BITS-1:1] == 2'd2);
  assign neg_y = (sel[SEL_BITS-1:1] == 2'd2) || (sel[SEL_BITS-1:1] == 2'd3);
  assign mag_a = swap ? {1'b0, job.y} : {1'b0, job.x};
  assign mag_b = swap ? {1'b0, job.x} : {1'b0, job.y};
  assign px    = neg_x ? COORD_BITS'(0) - mag_a : mag_a;
  assign py    = neg_y ? COORD_BITS'(0) - mag_b : mag_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid <= 1'b0;
    end else if (q_pop) begin
      jvalid <= 1'b1;
    end else if (emit && emit_last) begin
      jvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_head;
      pend <= head_pend;
    end else if (emit) begin
      pend <= pend_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      done_res <= job.done;
      last     <= emit_last;
      if (pend == '0) begin
        point_x     <= '0;
        point_y     <= '0;
        point_valid <= 1'b0;
      end else begin
        point_x     <= px;
        point_y     <= py;
        point_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/midpoint_circle_point_generator.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator
// Incremental midpoint circle rasteriser centred on the origin.
//
// Input channel (in_valid / in_stall): func, radius, quadrants. A start
// transaction loads the radius and quadrant mask and gives no result. A
// step transaction gives two points per enabled quadrant, the last one
// flagged by last, or one result with point_valid low when there is
// nothing to plot (empty mask or no walk in progress). done_res is high on
// every result of the step after which x exceeds y.
// Output channel (out_valid / out_stall): one result per cycle while
// out_stall is low. The first result of a step passes through the job
// queue, the job register and the output register. A step with all four
// quadrants enabled gives eight results; the walk front end takes one
// transaction per cycle until the four-entry job queue fills.
// Reset clears the walk, the queue and the output valid flag. While the
// receiver stalls, the current result holds, the queue fills and then
// in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_point_generator
  import mcpg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    func,
  input  wire logic [RADIUS_BITS-1:0]  radius,
  input  wire logic [QUAD_BITS-1:0]    quadrants,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         point_valid,
  output logic                         last,
  output logic                         done_res
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  mcpg_job_t q_job;
  mcpg_job_t q_head;

  mcpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .radius    (radius),
    .quadrants (quadrants),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  mcpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mcpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .last        (last),
    .done_res    (done_res)
  );

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> last)
    else $error("result without a point not marked last");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> (point_x == '0) && (point_y == '0))
    else $error("result without a point carries coordinates");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_queue_push_pop: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop && q_full) == 1'b0)
    else $error("job queue overflow");

endmodule

`default_nettype wire
